FILE: rtl/vfc_pkg.sv
// shared widths, constants, register indexes and types of the view frustum cull block
package vfc_pkg;

   localparam int COORD_W   = 24;
   localparam int COEF_W    = 16;
   localparam int ROW_W     = 3 * COEF_W;
   localparam int SCALE_W   = 24;
   localparam int FRAC_SH   = 14;
   localparam int PROD_W    = COORD_W + COEF_W;
   localparam int VIEW_W    = PROD_W + 2;
   localparam int V8_W      = VIEW_W - FRAC_SH;
   localparam int NUM_W     = V8_W + SCALE_W + 1;
   localparam int PIX_SH    = 8;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = ROW_W;

   localparam int X_LIMIT = 240;
   localparam int Y_LIMIT = 180;

   localparam logic [ROW_W-1:0]          ROW_X_RESET  = ROW_W'(64'd16384);
   localparam logic [ROW_W-1:0]          ROW_Y_RESET  = ROW_W'(64'd16384 << 16);
   localparam logic [ROW_W-1:0]          ROW_Z_RESET  = ROW_W'(64'd16384 << 32);
   localparam logic signed [COORD_W-1:0] FAR_RESET    = COORD_W'(-2560000);
   localparam logic [SCALE_W-1:0]        SCALE_RESET  = SCALE_W'(65536);
   // -1.0 in view space after the 2^14 coefficient scaling
   localparam logic signed [VIEW_W-1:0]  NEAR_LIMIT   = -(VIEW_W'(1) <<< (FRAC_SH + PIX_SH));

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_X   = 4'd0,
      CSR_ROW_Y   = 4'd1,
      CSR_ROW_Z   = 4'd2,
      CSR_SHIFT_X = 4'd3,
      CSR_SHIFT_Y = 4'd4,
      CSR_SHIFT_Z = 4'd5,
      CSR_FAR     = 4'd6,
      CSR_SCALE   = 4'd7
   } vfc_csr_type;

   // load enables of the four pipeline stages
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
      logic s4;
   } vfc_load_type;

endpackage

FILE: rtl/vfc_xform.sv
// view transform: nine coefficient products, then row sums plus translation
module vfc_xform (
   input  logic                                clock,
   input  vfc_pkg::vfc_load_type               load,
   input  logic signed [vfc_pkg::COORD_W-1:0]  pos_x,
   input  logic signed [vfc_pkg::COORD_W-1:0]  pos_y,
   input  logic signed [vfc_pkg::COORD_W-1:0]  pos_z,
   input  logic [vfc_pkg::ROW_W-1:0]           row_x,
   input  logic [vfc_pkg::ROW_W-1:0]           row_y,
   input  logic [vfc_pkg::ROW_W-1:0]           row_z,
   input  logic signed [vfc_pkg::COORD_W-1:0]  shift_x,
   input  logic signed [vfc_pkg::COORD_W-1:0]  shift_y,
   input  logic signed [vfc_pkg::COORD_W-1:0]  shift_z,
   output logic signed [vfc_pkg::VIEW_W-1:0]   view_x,
   output logic signed [vfc_pkg::VIEW_W-1:0]   view_y,
   output logic signed [vfc_pkg::VIEW_W-1:0]   view_z
);

   logic [vfc_pkg::ROW_W-1:0]           rows [3];
   logic signed [vfc_pkg::COORD_W-1:0]  pos [3];
   logic signed [vfc_pkg::COORD_W-1:0]  shifts [3];
   logic signed [vfc_pkg::COEF_W-1:0]   coef [3][3];
   logic signed [vfc_pkg::PROD_W-1:0]   prod_in [3][3];
   logic signed [vfc_pkg::PROD_W-1:0]   prod_ff [3][3];
   logic signed [vfc_pkg::VIEW_W-1:0]   view_in [3];
   logic signed [vfc_pkg::VIEW_W-1:0]   view_ff [3];

   always_comb begin
      rows[0]   = row_x;
      rows[1]   = row_y;
      rows[2]   = row_z;
      pos[0]    = pos_x;
      pos[1]    = pos_y;
      pos[2]    = pos_z;
      shifts[0] = shift_x;
      shifts[1] = shift_y;
      shifts[2] = shift_z;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            coef[r][c]    = $signed(rows[r][c*vfc_pkg::COEF_W +: vfc_pkg::COEF_W]);
            prod_in[r][c] = coef[r][c] * pos[c];
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         view_in[r] = vfc_pkg::VIEW_W'(prod_ff[r][0]) + vfc_pkg::VIEW_W'(prod_ff[r][1])
                    + vfc_pkg::VIEW_W'(prod_ff[r][2])
                    + (vfc_pkg::VIEW_W'(shifts[r]) <<< vfc_pkg::FRAC_SH);
      end
   end

   always_ff @(posedge clock) begin
      if (load.s1) begin
         prod_ff <= prod_in;
      end
      if (load.s2) begin
         view_ff <= view_in;
      end
   end

   assign view_x = view_ff[0];
   assign view_y = view_ff[1];
   assign view_z = view_ff[2];

endmodule

FILE: rtl/vfc_proj.sv
// depth tests and screen bound tests done as multiply and compare
module vfc_proj (
   input  logic                                clock,
   input  vfc_pkg::vfc_load_type               load,
   input  logic signed [vfc_pkg::VIEW_W-1:0]   view_x,
   input  logic signed [vfc_pkg::VIEW_W-1:0]   view_y,
   input  logic signed [vfc_pkg::VIEW_W-1:0]   view_z,
   input  logic signed [vfc_pkg::COORD_W-1:0]  far_limit,
   input  logic [vfc_pkg::SCALE_W-1:0]         focal_scale,
   output logic                                culled
);

   localparam logic signed [vfc_pkg::NUM_W-1:0] X_BOUND = vfc_pkg::NUM_W'(vfc_pkg::X_LIMIT + 1);
   localparam logic signed [vfc_pkg::NUM_W-1:0] Y_BOUND = vfc_pkg::NUM_W'(vfc_pkg::Y_LIMIT + 1);

   logic signed [vfc_pkg::VIEW_W-1:0]  far_q22;
   logic signed [vfc_pkg::V8_W-1:0]    x8;
   logic signed [vfc_pkg::V8_W-1:0]    y8;
   logic signed [vfc_pkg::V8_W:0]      mag_z;
   logic signed [vfc_pkg::SCALE_W:0]   scale_s;
   logic signed [vfc_pkg::NUM_W-1:0]   mag_z_ext;

   logic                               depth_in;
   logic                               depth_ff;
   logic signed [vfc_pkg::NUM_W-1:0]   num_x_in;
   logic signed [vfc_pkg::NUM_W-1:0]   num_x_ff;
   logic signed [vfc_pkg::NUM_W-1:0]   num_y_in;
   logic signed [vfc_pkg::NUM_W-1:0]   num_y_ff;
   logic signed [vfc_pkg::NUM_W-1:0]   thr_x_in;
   logic signed [vfc_pkg::NUM_W-1:0]   thr_x_ff;
   logic signed [vfc_pkg::NUM_W-1:0]   thr_y_in;
   logic signed [vfc_pkg::NUM_W-1:0]   thr_y_ff;
   logic                               culled_in;
   logic                               culled_ff;

   always_comb begin
      far_q22   = vfc_pkg::VIEW_W'(far_limit) <<< vfc_pkg::FRAC_SH;
      depth_in  = (view_z > vfc_pkg::NEAR_LIMIT) || (view_z < far_q22);
      x8        = vfc_pkg::V8_W'(view_x >>> vfc_pkg::FRAC_SH);
      y8        = vfc_pkg::V8_W'(view_y >>> vfc_pkg::FRAC_SH);
      // view z is at most -1.0 when the bounds matter, so its negation is the divisor size
      mag_z     = -(vfc_pkg::V8_W'(view_z >>> vfc_pkg::FRAC_SH));
      scale_s   = $signed({1'b0, focal_scale});
      mag_z_ext = vfc_pkg::NUM_W'(mag_z);
      num_x_in  = x8 * scale_s;
      num_y_in  = y8 * scale_s;
      thr_x_in  = (mag_z_ext * X_BOUND) <<< vfc_pkg::PIX_SH;
      thr_y_in  = (mag_z_ext * Y_BOUND) <<< vfc_pkg::PIX_SH;
   end

   // truncated quotient leaves the bound exactly when |num| reaches (limit+1)*|den|
   always_comb begin
      culled_in = depth_ff
               || (num_x_ff >= thr_x_ff) || (num_x_ff <= -thr_x_ff)
               || (num_y_ff >= thr_y_ff) || (num_y_ff <= -thr_y_ff);
   end

   always_ff @(posedge clock) begin
      if (load.s3) begin
         depth_ff <= depth_in;
         num_x_ff <= num_x_in;
         num_y_ff <= num_y_in;
         thr_x_ff <= thr_x_in;
         thr_y_ff <= thr_y_in;
      end
      if (load.s4) begin
         culled_ff <= culled_in;
      end
   end

   assign culled = culled_ff;

endmodule

FILE: rtl/view_point_frustum_cull.sv
// top level of the view frustum cull block: registers, pipeline control, datapath
//
//   channel   direction   handshake            payload
//   req       in          req_valid/req_stall  req_pos_x, req_pos_y, req_pos_z
//   rsp       out         rsp_valid/rsp_stall  rsp_culled
//   csr       in          csr_we               csr_index, csr_wdata
//
// four register stages: coefficient products, row sums, projection products,
// bound compares into the output register; one point per cycle unless rsp_stall holds it.
// each stage loads whenever it is empty or the stage after it moves, so a held
// result only stops stages that are full behind it.
// reset clears the valid bits and loads the register defaults.
module view_point_frustum_cull (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [vfc_pkg::COORD_W-1:0]      req_pos_x,
   input  logic signed [vfc_pkg::COORD_W-1:0]      req_pos_y,
   input  logic signed [vfc_pkg::COORD_W-1:0]      req_pos_z,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_culled,
   input  logic                                    csr_we,
   input  logic [vfc_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [vfc_pkg::CSR_DAT_W-1:0]           csr_wdata
);

   logic [vfc_pkg::ROW_W-1:0]           row_x_ff;
   logic [vfc_pkg::ROW_W-1:0]           row_y_ff;
   logic [vfc_pkg::ROW_W-1:0]           row_z_ff;
   logic signed [vfc_pkg::COORD_W-1:0]  shift_x_ff;
   logic signed [vfc_pkg::COORD_W-1:0]  shift_y_ff;
   logic signed [vfc_pkg::COORD_W-1:0]  shift_z_ff;
   logic signed [vfc_pkg::COORD_W-1:0]  far_ff;
   logic [vfc_pkg::SCALE_W-1:0]         scale_ff;

   logic [3:0]                          valid_ff;
   logic [3:0]                          valid_in;
   vfc_pkg::vfc_load_type               load;

   logic signed [vfc_pkg::VIEW_W-1:0]   view_x;
   logic signed [vfc_pkg::VIEW_W-1:0]   view_y;
   logic signed [vfc_pkg::VIEW_W-1:0]   view_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_x_ff   <= vfc_pkg::ROW_X_RESET;
         row_y_ff   <= vfc_pkg::ROW_Y_RESET;
         row_z_ff   <= vfc_pkg::ROW_Z_RESET;
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         shift_z_ff <= '0;
         far_ff     <= vfc_pkg::FAR_RESET;
         scale_ff   <= vfc_pkg::SCALE_RESET;
      end else if (csr_we) begin
         case (vfc_pkg::vfc_csr_type'(csr_index))
            vfc_pkg::CSR_ROW_X:   row_x_ff   <= csr_wdata[vfc_pkg::ROW_W-1:0];
            vfc_pkg::CSR_ROW_Y:   row_y_ff   <= csr_wdata[vfc_pkg::ROW_W-1:0];
            vfc_pkg::CSR_ROW_Z:   row_z_ff   <= csr_wdata[vfc_pkg::ROW_W-1:0];
            vfc_pkg::CSR_SHIFT_X: shift_x_ff <= $signed(csr_wdata[vfc_pkg::COORD_W-1:0]);
            vfc_pkg::CSR_SHIFT_Y: shift_y_ff <= $signed(csr_wdata[vfc_pkg::COORD_W-1:0]);
            vfc_pkg::CSR_SHIFT_Z: shift_z_ff <= $signed(csr_wdata[vfc_pkg::COORD_W-1:0]);
            vfc_pkg::CSR_FAR:     far_ff     <= $signed(csr_wdata[vfc_pkg::COORD_W-1:0]);
            vfc_pkg::CSR_SCALE:   scale_ff   <= csr_wdata[vfc_pkg::SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // a stage loads when it is empty or its contents move on
   always_comb begin
      load.s4  = !valid_ff[3] || !rsp_stall;
      load.s3  = !valid_ff[2] || load.s4;
      load.s2  = !valid_ff[1] || load.s3;
      load.s1  = !valid_ff[0] || load.s2;
      valid_in = valid_ff;
      if (load.s1) begin
         valid_in[0] = req_valid;
      end
      if (load.s2) begin
         valid_in[1] = valid_ff[0];
      end
      if (load.s3) begin
         valid_in[2] = valid_ff[1];
      end
      if (load.s4) begin
         valid_in[3] = valid_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load.s1;
   assign rsp_valid = valid_ff[3];

   vfc_xform u_xform (
      .clock   (clock),
      .load    (load),
      .pos_x   (req_pos_x),
      .pos_y   (req_pos_y),
      .pos_z   (req_pos_z),
      .row_x   (row_x_ff),
      .row_y   (row_y_ff),
      .row_z   (row_z_ff),
      .shift_x (shift_x_ff),
      .shift_y (shift_y_ff),
      .shift_z (shift_z_ff),
      .view_x  (view_x),
      .view_y  (view_y),
      .view_z  (view_z)
   );

   vfc_proj u_proj (
      .clock       (clock),
      .load        (load),
      .view_x      (view_x),
      .view_y      (view_y),
      .view_z      (view_z),
      .far_limit   (far_ff),
      .focal_scale (scale_ff),
      .culled      (rsp_culled)
   );

endmodule
